### sv/data_packet_framer_xor_macros.svh
// Assertion macros used by the framer top level.
`ifndef DATA_PACKET_FRAMER_XOR_MACROS_SVH
`define DATA_PACKET_FRAMER_XOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define DPFX_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dpfx assertion failed");

// Next-cycle implication, checked outside reset.
`define DPFX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpfx assertion failed");

`else

`define DPFX_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DPFX_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### sv/dpfx_pkg.sv
// Package with constants, the job descriptor and the emit step codes of the framer.
`timescale 1ns / 1ps

package dpfx_pkg;

  // Default payload bytes per packet.
  localparam int DPFX_CHUNK = 512;

  // Control byte that opens a data packet.
  localparam logic [7:0] DPFX_CTRL_DATA = 8'h01;

  // Width of the file size register and the file position.
  localparam int DPFX_FS_W = 31;

  // Bytes a packet is built from, captured when a payload byte is taken.
  typedef struct packed {
    logic       hdr;      // header goes out before the payload byte
    logic [7:0] seq;      // sequence number of this packet
    logic [7:0] len_hi;   // payload length, high byte
    logic [7:0] len_lo;   // payload length, low byte
    logic [7:0] data;     // payload byte
    logic [7:0] chk;      // checksum of the packet through this byte
    logic       eop;      // this byte ends the packet
    logic       trailer;  // an empty packet follows
  } dpfx_job_t;

  // Output byte being emitted for the current job.
  typedef enum logic [3:0] {
    ST_CTRL,
    ST_SEQ,
    ST_LENH,
    ST_LENL,
    ST_DATA,
    ST_CHK,
    ST_TCTRL,
    ST_TSEQ,
    ST_TLENH,
    ST_TLENL,
    ST_TCHK
  } dpfx_step_t;

endpackage

### sv/dpfx_framer.sv
// Packet bookkeeping: positions, sequence number and checksum, and the job for each byte.
`timescale 1ns / 1ps

module dpfx_framer #(
  parameter int CHUNK = dpfx_pkg::DPFX_CHUNK
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic [7:0]                        data_byte,
  input  logic [dpfx_pkg::DPFX_FS_W-1:0]    file_size,
  output dpfx_pkg::dpfx_job_t               job
);
  import dpfx_pkg::*;

  localparam int LEN_W = $clog2(CHUNK + 1);

  logic [7:0]           sequence_number;
  logic [DPFX_FS_W-1:0] file_position;
  logic [LEN_W-1:0]     chunk_position;
  logic [7:0]           running_xor;
  logic [LEN_W-1:0]     pkt_len;
  logic                 pkt_final;
  logic                 pkt_trailer;

  logic                 start;
  logic [DPFX_FS_W-1:0] fs_eff;
  logic [DPFX_FS_W-1:0] remaining;
  logic                 final_new;
  logic                 trailer_new;
  logic [LEN_W-1:0]     len_new;
  logic [LEN_W-1:0]     len_cur;
  logic                 final_cur;
  logic                 trailer_cur;
  logic [15:0]          len16;
  logic [7:0]           xor_base;
  logic [7:0]           xor_data;
  logic [LEN_W-1:0]     cp_inc;
  logic                 eop;

  // Packet parameters, worked out when a packet starts.
  always_comb begin
    start       = (chunk_position == '0);
    fs_eff      = (file_size == '0) ? DPFX_FS_W'(1) : file_size;
    remaining   = (fs_eff > file_position) ? (fs_eff - file_position) : DPFX_FS_W'(1);
    final_new   = (remaining <= DPFX_FS_W'(CHUNK));
    trailer_new = final_new && (remaining == DPFX_FS_W'(CHUNK));
    len_new     = final_new ? LEN_W'(remaining) : LEN_W'(CHUNK);
    len_cur     = start ? len_new : pkt_len;
    final_cur   = start ? final_new : pkt_final;
    trailer_cur = start ? trailer_new : pkt_trailer;
    len16       = 16'(len_cur);
  end

  // Checksum and end of packet for this byte.
  always_comb begin
    xor_base = start ? (DPFX_CTRL_DATA ^ sequence_number ^ len16[15:8] ^ len16[7:0])
                     : running_xor;
    xor_data = xor_base ^ data_byte;
    cp_inc   = (start ? '0 : chunk_position) + LEN_W'(1);
    eop      = (cp_inc >= len_cur);
  end

  // Job handed to the serializer.
  always_comb begin
    job.hdr     = start;
    job.seq     = sequence_number;
    job.len_hi  = len16[15:8];
    job.len_lo  = len16[7:0];
    job.data    = data_byte;
    job.chk     = xor_data;
    job.eop     = eop;
    job.trailer = eop && final_cur && trailer_cur;
  end

  // Packet state update on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_number <= '0;
      file_position   <= '0;
      chunk_position  <= '0;
      running_xor     <= '0;
      pkt_len         <= '0;
      pkt_final       <= 1'b0;
      pkt_trailer     <= 1'b0;
    end else if (load) begin
      if (start) begin
        pkt_len     <= len_new;
        pkt_final   <= final_new;
        pkt_trailer <= trailer_new;
      end
      if (eop) begin
        sequence_number <= sequence_number + ((final_cur && trailer_cur) ? 8'd2 : 8'd1);
        chunk_position  <= '0;
        running_xor     <= '0;
        file_position   <= final_cur ? '0 : file_position + DPFX_FS_W'(1);
      end else begin
        chunk_position <= cp_inc;
        running_xor    <= xor_data;
        file_position  <= file_position + DPFX_FS_W'(1);
      end
    end
  end

endmodule

### sv/dpfx_serializer.sv
// Output stage that holds one job and sends its bytes one beat at a time.
`timescale 1ns / 1ps

module dpfx_serializer (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  dpfx_pkg::dpfx_job_t job_in,
  output logic                ready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // out_byte
  output logic                m_tuser,   // end_of_packet
  output logic                m_tlast    // last
);
  import dpfx_pkg::*;

  dpfx_job_t  job;
  dpfx_step_t step;
  dpfx_step_t step_next;
  logic       busy;
  logic       busy_next;
  logic [7:0] seq2;
  logic       advance;

  // Busy flag and step register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ST_CTRL;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

  // The job payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      job <= job_in;
    end
  end

  // Current beat, next step and handover to the next job.
  always_comb begin
    seq2     = job.seq + 8'd1;
    m_tvalid = busy;
    m_tuser  = 1'b0;
    m_tlast  = 1'b0;
    m_tdata  = '0;
    case (step)
      ST_CTRL:  m_tdata = DPFX_CTRL_DATA;
      ST_SEQ:   m_tdata = job.seq;
      ST_LENH:  m_tdata = job.len_hi;
      ST_LENL:  m_tdata = job.len_lo;
      ST_DATA: begin
        m_tdata = job.data;
        m_tlast = !job.eop;
      end
      ST_CHK: begin
        m_tdata = job.chk;
        m_tuser = 1'b1;
        m_tlast = !job.trailer;
      end
      ST_TCTRL: m_tdata = DPFX_CTRL_DATA;
      ST_TSEQ:  m_tdata = seq2;
      ST_TLENH: m_tdata = 8'h00;
      ST_TLENL: m_tdata = 8'h00;
      ST_TCHK: begin
        m_tdata = DPFX_CTRL_DATA ^ seq2;
        m_tuser = 1'b1;
        m_tlast = 1'b1;
      end
      default:  m_tdata = '0;
    endcase

    advance   = busy && m_tready;
    ready     = !busy || (m_tready && m_tlast);
    busy_next = busy;
    step_next = step;
    if (load) begin
      busy_next = 1'b1;
      step_next = job_in.hdr ? ST_CTRL : ST_DATA;
    end else if (advance) begin
      if (m_tlast) begin
        busy_next = 1'b0;
      end else begin
        case (step)
          ST_CTRL:  step_next = ST_SEQ;
          ST_SEQ:   step_next = ST_LENH;
          ST_LENH:  step_next = ST_LENL;
          ST_LENL:  step_next = ST_DATA;
          ST_DATA:  step_next = ST_CHK;
          ST_CHK:   step_next = ST_TCTRL;
          ST_TCTRL: step_next = ST_TSEQ;
          ST_TSEQ:  step_next = ST_TLENH;
          ST_TLENH: step_next = ST_TLENL;
          ST_TLENL: step_next = ST_TCHK;
          default:  step_next = ST_CTRL;
        endcase
      end
    end
  end

endmodule

### sv/data_packet_framer_xor.sv
// Top level of the data packet framer with XOR checksum.
// File bytes enter one per beat and leave framed as data packets of at most
// CHUNK payload bytes: control byte 0x01, sequence number, length high and
// low, the payload, then the XOR of the packet's earlier bytes (marked in
// m_tuser). m_tlast marks the final output beat caused by an input beat.
// A payload byte inside a packet is a single beat; a byte that opens a
// packet adds four header beats, one that closes it adds the checksum
// beat, and a file whose size is a nonzero multiple of CHUNK adds an
// empty packet of five beats. The output serializer sets the rate, sending
// one beat per cycle while m_tready is high; a new input beat is taken in
// the same cycle the previous job's last beat leaves. file_size, sampled
// at each packet start, is written through cfg_we/cfg_wdata; the user must
// do so only while the block is idle, which the block does not check.
`timescale 1ns / 1ps
`include "data_packet_framer_xor_macros.svh"

module data_packet_framer_xor #(
  parameter int CHUNK = dpfx_pkg::DPFX_CHUNK
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dpfx_pkg::DPFX_FS_W-1:0] cfg_wdata,  // file_size
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,    // data_byte
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,    // out_byte
  output logic                           m_tuser,    // end_of_packet
  output logic                           m_tlast     // last
);
  import dpfx_pkg::*;

  logic [DPFX_FS_W-1:0] file_size;
  logic                 load;
  dpfx_job_t            job;

  // File size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= DPFX_FS_W'(1);
    end else if (cfg_we) begin
      file_size <= cfg_wdata;
    end
  end

  assign load = s_tvalid && s_tready;

  dpfx_framer #(
    .CHUNK(CHUNK)
  ) u_framer (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .data_byte(s_tdata),
    .file_size(file_size),
    .job      (job)
  );

  dpfx_serializer u_serializer (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .job_in  (job),
    .ready   (s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  // A stalled output beat blocks the input side.
  `DPFX_ASSERT_IMPL(a_stall_blocks_input, clk, rst, m_tvalid && !m_tready, !s_tready)
  // An accepted input beat always produces output in the next cycle.
  `DPFX_ASSERT_NEXT(a_accept_gives_output, clk, rst, load, m_tvalid)
  // A job that is not finished keeps its output valid.
  `DPFX_ASSERT_NEXT(a_job_continues, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule
